### sv/rmss_pkg.sv
// ----------------------------------------------------------------------------
// rmss_pkg
// Shared types, constants and fixed-point helpers of the rope step unit.
// ----------------------------------------------------------------------------
package rmss_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int CNT_W     = 7;
    localparam int CFG_IW    = 3;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_NODE_COUNT  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_SPRING_K    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_REST_LENGTH = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_NODE_MASS   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_TIME_STEP   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_GRAVITY_X   = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_GRAVITY_Y   = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_INTEGRATOR  = 3'd7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic INTEG_EULER  = 1'b0;
    localparam logic INTEG_VERLET = 1'b1;

    localparam logic [CNT_W-1:0]  RST_NODE_COUNT  = 7'd2;
    localparam logic [31:0]       RST_SPRING_K    = 32'd65536;
    localparam logic [31:0]       RST_REST_LENGTH = 32'd65536;
    localparam logic [31:0]       RST_NODE_MASS   = 32'd65536;
    localparam logic [15:0]       RST_TIME_STEP   = 16'd655;
    localparam logic signed [31:0] RST_GRAVITY_X  = 32'sd0;
    localparam logic signed [31:0] RST_GRAVITY_Y  = -32'sd655360;

    localparam logic signed [32:0] EULER_DAMP_Q16  = 33'sd655;
    localparam logic signed [32:0] VERLET_KEEP_Q16 = 33'sd65533;

    // Iterative units.
    localparam int DIV_W      = 64;
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = DIV_W / DIV_STEP;
    localparam int DIV_CW     = $clog2(DIV_CYCLES);
    localparam int SQ_ROOT_W  = 32;
    localparam int SQ_STEP    = 2;
    localparam int SQ_CYCLES  = SQ_ROOT_W / SQ_STEP;
    localparam int SQ_CW      = $clog2(SQ_CYCLES);

    localparam logic signed [51:0] SAT_HI = 52'sd2147483647;
    localparam logic signed [51:0] SAT_LO = -52'sd2147483648;

    typedef struct packed {
        logic               op;
        logic [5:0]         node_index;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic               pinned;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         out_index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               last_node;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               pin;
    } t_node_rec;

    function automatic logic signed [31:0] f_sat32(input logic signed [51:0] v);
        if (v > SAT_HI) begin
            return 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            return -32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Signed result from a magnitude and a sign, saturated.
    function automatic logic signed [31:0] f_sat_mag(input logic [63:0] q, input logic neg);
        logic [31:0] t;
        t = q[31:0];
        if (neg) begin
            if (q > 64'd2147483648) begin
                return -32'sh80000000;
            end
            return signed'(32'(-t));
        end
        if (q > 64'd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        return signed'(t);
    endfunction

    function automatic logic [32:0] f_abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // Product magnitude shifted down by 16, truncated toward zero.
    function automatic logic signed [49:0] f_q16(input logic [64:0] mag, input logic neg);
        logic signed [49:0] m;
        m = signed'({1'b0, mag[64:16]});
        return neg ? -m : m;
    endfunction

endpackage

### sv/rmss_div.sv
// ----------------------------------------------------------------------------
// rmss_div
// Unsigned restoring divider, several quotient bits per clock.
// ----------------------------------------------------------------------------
module rmss_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rmss_pkg::DIV_W-1:0]    i_dividend,
    input  logic [31:0]                   i_divisor,
    output logic                          o_done,
    output logic [rmss_pkg::DIV_W-1:0]    o_quotient
);
    import rmss_pkg::*;

    localparam logic [DIV_CW-1:0] LAST = DIV_CW'(DIV_CYCLES - 1);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_W-1:0]  r_q;
    logic [31:0]       r_rem;
    logic [31:0]       r_div;
    logic [DIV_W-1:0]  n_q;
    logic [31:0]       n_rem;

    always_comb begin
        logic [32:0] rem;
        rem = {1'b0, r_rem};
        n_q = r_q;
        for (int k = 0; k < DIV_STEP; k++) begin
            rem = {rem[31:0], n_q[DIV_W-1]};
            n_q = {n_q[DIV_W-2:0], 1'b0};
            if (rem >= {1'b0, r_div}) begin
                rem    = rem - {1'b0, r_div};
                n_q[0] = 1'b1;
            end
        end
        n_rem = rem[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

### sv/rmss_isqrt.sv
// ----------------------------------------------------------------------------
// rmss_isqrt
// Integer square root of a 64-bit value, digit by digit, two bits per clock.
// ----------------------------------------------------------------------------
module rmss_isqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [63:0]                      i_radicand,
    output logic                             o_done,
    output logic [rmss_pkg::SQ_ROOT_W-1:0]   o_root
);
    import rmss_pkg::*;

    localparam logic [SQ_CW-1:0] LAST = SQ_CW'(SQ_CYCLES - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [SQ_CW-1:0]     r_cnt;
    logic [63:0]          r_v;
    logic [33:0]          r_rem;
    logic [SQ_ROOT_W-1:0] r_root;
    logic [63:0]          n_v;
    logic [33:0]          n_rem;
    logic [SQ_ROOT_W-1:0] n_root;

    always_comb begin
        logic [35:0] rem;
        logic [35:0] trial;
        rem    = {2'b00, r_rem};
        n_v    = r_v;
        n_root = r_root;
        for (int k = 0; k < SQ_STEP; k++) begin
            rem   = {rem[33:0], n_v[63:62]};
            n_v   = {n_v[61:0], 2'b00};
            trial = {2'b00, n_root, 2'b01};
            if (rem >= trial) begin
                rem    = rem - trial;
                n_root = {n_root[SQ_ROOT_W-2:0], 1'b1};
            end else begin
                n_root = {n_root[SQ_ROOT_W-2:0], 1'b0};
            end
        end
        n_rem = rem[33:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v    <= n_v;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### sv/rope_mass_spring_step_unit.sv
// ----------------------------------------------------------------------------
// rope_mass_spring_step_unit
// Mass-spring chain integrator, one time step per step transaction.
// ----------------------------------------------------------------------------
// A load transaction writes one node and returns nothing. A step transaction
// walks the chain node by node and returns one result per node in ascending
// order, the last one flagged. The last node has no spring of its own and
// skips the spring states, and a pinned node skips the integration. A step
// also waits whenever the output side stalls. The per-node sequence is a
// square root for the spring length, a divider pass for the spring direction
// and another for the acceleration, around one shared multiplier and a node
// memory with a registered read. No transaction is taken until the step's
// last result has been loaded into the output register.
module rope_mass_spring_step_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rmss_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rmss_pkg::t_out_item         o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rmss_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);
    import rmss_pkg::*;

    typedef enum logic [34:0] {
        S_IDLE = 35'(1) << 0,  S_RD0  = 35'(1) << 1,  S_RDN  = 35'(1) << 2,
        S_DIFF = 35'(1) << 3,  S_SQX  = 35'(1) << 4,  S_SQY  = 35'(1) << 5,
        S_SQS  = 35'(1) << 6,  S_SQW  = 35'(1) << 7,  S_STR  = 35'(1) << 8,
        S_FK   = 35'(1) << 9,  S_FV   = 35'(1) << 10, S_MX   = 35'(1) << 11,
        S_MY   = 35'(1) << 12, S_DIVS = 35'(1) << 13, S_DIVW = 35'(1) << 14,
        S_SUM  = 35'(1) << 15, S_GX   = 35'(1) << 16, S_GY   = 35'(1) << 17,
        S_DX   = 35'(1) << 18, S_DY   = 35'(1) << 19, S_ACC  = 35'(1) << 20,
        S_ACW  = 35'(1) << 21, S_AV   = 35'(1) << 22, S_V1   = 35'(1) << 23,
        S_V2   = 35'(1) << 24, S_V3   = 35'(1) << 25, S_V4   = 35'(1) << 26,
        S_W1   = 35'(1) << 27, S_W2   = 35'(1) << 28, S_W3   = 35'(1) << 29,
        S_W4   = 35'(1) << 30, S_W5   = 35'(1) << 31, S_W6   = 35'(1) << 32,
        S_W7   = 35'(1) << 33, S_EMIT = 35'(1) << 34
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration.
    logic [CNT_W-1:0]   r_node_count;
    logic [31:0]        r_spring_k;
    logic [31:0]        r_rest_length;
    logic [31:0]        r_node_mass;
    logic [15:0]        r_time_step;
    logic signed [31:0] r_gravity_x;
    logic signed [31:0] r_gravity_y;
    logic               r_integrator;

    // Control.
    logic [NODE_AW-1:0]   r_idx;
    logic [CNT_W-1:0]     r_n;
    logic                 r_out_valid;
    t_out_item            r_out;

    // Node memory.
    t_node_rec r_node_mem [MAX_NODES];
    t_node_rec r_rd;

    // Datapath.
    t_node_rec          r_cur;
    t_node_rec          r_nxt;
    logic signed [31:0] r_fpx, r_fpy, r_fx, r_fy;
    logic signed [31:0] r_dx, r_dy, r_f, r_stretch;
    logic [31:0]        r_len;
    logic [63:0]        r_sq;
    logic [64:0]        r_prod, r_prodx;
    logic               r_pneg, r_pnegx, r_pnegy;
    logic signed [31:0] r_tx, r_ty;
    logic signed [31:0] r_npx, r_npy, r_nqx, r_nqy, r_nvx, r_nvy;
    logic signed [32:0] r_sx, r_sy, r_cx, r_cy;

    logic               in_acc;
    logic               out_load;
    logic               has_next;
    logic [CNT_W-1:0]   n_eff;
    logic [NODE_AW-1:0] rd_addr;
    logic [NODE_AW-1:0] wr_addr;
    logic               mem_we;
    t_node_rec          wr_data;
    logic signed [32:0] m_a, m_b;
    logic [64:0]        m_mag;
    logic signed [49:0] prod_q16;
    logic signed [31:0] prod_s32;
    logic signed [32:0] dt33;
    logic [32:0]        abs_tx, abs_ty;

    logic               sq_start, sq_done;
    logic [SQ_ROOT_W-1:0] sq_root;
    logic               dv_start, dvx_done, dvy_done;
    logic [DIV_W-1:0]   dvx_num, dvy_num, dvx_q, dvy_q;
    logic [31:0]        dv_den;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign has_next = ((CNT_W'(r_idx) + 7'd1) < r_n);
    assign dt33     = signed'({17'b0, r_time_step});

    always_comb begin
        if (r_node_count < 7'd2) begin
            n_eff = 7'd2;
        end else if (r_node_count > CNT_W'(MAX_NODES)) begin
            n_eff = CNT_W'(MAX_NODES);
        end else begin
            n_eff = r_node_count;
        end
    end

    // Shared multiplier; its product is registered every cycle.
    assign prod_q16 = f_q16(r_prod, r_pneg);
    assign prod_s32 = f_sat32(52'(prod_q16));

    always_comb begin
        case (r_state)
            S_SQX:   begin m_a = 33'(r_dx);      m_b = 33'(r_dx);      end
            S_SQY:   begin m_a = 33'(r_dy);      m_b = 33'(r_dy);      end
            S_FK:    begin m_a = signed'({1'b0, r_spring_k}); m_b = 33'(r_stretch); end
            S_MX:    begin m_a = 33'(r_f);       m_b = 33'(r_dx);      end
            S_MY:    begin m_a = 33'(r_f);       m_b = 33'(r_dy);      end
            S_SUM:   begin m_a = signed'({1'b0, r_node_mass}); m_b = 33'(r_gravity_x); end
            S_GX:    begin m_a = signed'({1'b0, r_node_mass}); m_b = 33'(r_gravity_y); end
            S_GY:    begin m_a = 33'(r_cur.vx);  m_b = EULER_DAMP_Q16;     end
            S_DX:    begin m_a = 33'(r_cur.vy);  m_b = EULER_DAMP_Q16;     end
            S_AV:    begin m_a = 33'(r_tx);      m_b = dt33;               end
            S_V1:    begin m_a = 33'(r_ty);      m_b = dt33;               end
            S_V2:    begin m_a = 33'(r_nvx);     m_b = dt33;               end
            S_V3:    begin m_a = 33'(r_nvy);     m_b = dt33;               end
            S_W1:    begin m_a = 33'(prod_q16);  m_b = dt33;               end
            S_W2:    begin m_a = 33'(r_ty);      m_b = dt33;               end
            S_W3:    begin m_a = 33'(prod_q16);  m_b = dt33;               end
            S_W4:    begin
                m_a = 33'(f_sat32(52'(r_cur.px) - 52'(r_cur.qx)));
                m_b = VERLET_KEEP_Q16;
            end
            S_W5:    begin
                m_a = 33'(f_sat32(52'(r_cur.py) - 52'(r_cur.qy)));
                m_b = VERLET_KEEP_Q16;
            end
            default: begin m_a = '0;             m_b = '0;             end
        endcase
    end

    assign m_mag = 65'(66'(f_abs33(m_a)) * 66'(f_abs33(m_b)));

    // Iterative units.
    assign sq_start = (r_state == S_SQS);

    rmss_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_sq + r_prod[63:0]),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    assign abs_tx = f_abs33(33'(r_tx));
    assign abs_ty = f_abs33(33'(r_ty));

    always_comb begin
        dv_start = 1'b0;
        dvx_num  = r_prodx[63:0];
        dvy_num  = r_prod[63:0];
        dv_den   = r_len;
        if (r_state == S_DIVS) begin
            dv_start = 1'b1;
        end else if (r_state == S_ACC) begin
            dv_start = (r_node_mass != 32'd0);
            dvx_num  = {16'b0, abs_tx[31:0], 16'b0};
            dvy_num  = {16'b0, abs_ty[31:0], 16'b0};
            dv_den   = r_node_mass;
        end
    end

    rmss_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dv_start),
        .i_dividend (dvx_num),
        .i_divisor  (dv_den),
        .o_done     (dvx_done),
        .o_quotient (dvx_q)
    );

    rmss_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dv_start),
        .i_dividend (dvy_num),
        .i_divisor  (dv_den),
        .o_done     (dvy_done),
        .o_quotient (dvy_q)
    );

    // Memory addressing. The next node is fetched while the current one is
    // written back, so reads run two entries ahead of the write in S_EMIT.
    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = '0;
            S_EMIT:  rd_addr = r_idx + NODE_AW'(2);
            default: rd_addr = r_idx + NODE_AW'(1);
        endcase
    end

    always_comb begin
        if (r_state == S_IDLE) begin
            mem_we      = in_acc && (i_in_data.op == OP_LOAD)
                          && (32'(i_in_data.node_index) < MAX_NODES);
            wr_addr     = NODE_AW'(i_in_data.node_index);
            wr_data.px  = i_in_data.load_x;
            wr_data.py  = i_in_data.load_y;
            wr_data.qx  = i_in_data.load_x;
            wr_data.qy  = i_in_data.load_y;
            wr_data.vx  = '0;
            wr_data.vy  = '0;
            wr_data.pin = i_in_data.pinned;
        end else begin
            mem_we      = out_load;
            wr_addr     = r_idx;
            wr_data.px  = r_npx;
            wr_data.py  = r_npy;
            wr_data.qx  = r_nqx;
            wr_data.qy  = r_nqy;
            wr_data.vx  = r_nvx;
            wr_data.vy  = r_nvy;
            wr_data.pin = r_cur.pin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_node_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_node_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc && (i_in_data.op == OP_STEP)) n_state = S_RD0;
            S_RD0:  n_state = S_RDN;
            S_RDN:  n_state = has_next ? S_DIFF : S_SUM;
            S_DIFF: n_state = S_SQX;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_SQS;
            S_SQS:  n_state = S_SQW;
            S_SQW:  if (sq_done) n_state = S_STR;
            S_STR:  n_state = S_FK;
            S_FK:   n_state = S_FV;
            S_FV:   n_state = (r_len == 32'd0) ? S_SUM : S_MX;
            S_MX:   n_state = S_MY;
            S_MY:   n_state = S_DIVS;
            S_DIVS: n_state = S_DIVW;
            S_DIVW: if (dvx_done) n_state = S_SUM;
            S_SUM:  n_state = r_cur.pin ? S_EMIT : S_GX;
            S_GX:   n_state = S_GY;
            S_GY:   n_state = (r_integrator == INTEG_VERLET) ? S_ACC : S_DX;
            S_DX:   n_state = S_DY;
            S_DY:   n_state = S_ACC;
            S_ACC:  n_state = (r_node_mass == 32'd0) ? S_AV : S_ACW;
            S_ACW:  if (dvx_done) n_state = S_AV;
            S_AV:   n_state = (r_integrator == INTEG_VERLET) ? S_W1 : S_V1;
            S_V1:   n_state = S_V2;
            S_V2:   n_state = S_V3;
            S_V3:   n_state = S_V4;
            S_V4:   n_state = S_EMIT;
            S_W1:   n_state = S_W2;
            S_W2:   n_state = S_W3;
            S_W3:   n_state = S_W4;
            S_W4:   n_state = S_W5;
            S_W5:   n_state = S_W6;
            S_W6:   n_state = S_W7;
            S_W7:   n_state = S_EMIT;
            S_EMIT: if (out_load) n_state = has_next ? S_RDN : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_n           <= RST_NODE_COUNT;
            r_out_valid   <= 1'b0;
            r_node_count  <= RST_NODE_COUNT;
            r_spring_k    <= RST_SPRING_K;
            r_rest_length <= RST_REST_LENGTH;
            r_node_mass   <= RST_NODE_MASS;
            r_time_step   <= RST_TIME_STEP;
            r_gravity_x   <= RST_GRAVITY_X;
            r_gravity_y   <= RST_GRAVITY_Y;
            r_integrator  <= INTEG_EULER;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NODE_COUNT:  r_node_count  <= i_cfg_data[CNT_W-1:0];
                    CFG_SPRING_K:    r_spring_k    <= i_cfg_data;
                    CFG_REST_LENGTH: r_rest_length <= i_cfg_data;
                    CFG_NODE_MASS:   r_node_mass   <= i_cfg_data;
                    CFG_TIME_STEP:   r_time_step   <= i_cfg_data[15:0];
                    CFG_GRAVITY_X:   r_gravity_x   <= signed'(i_cfg_data);
                    CFG_GRAVITY_Y:   r_gravity_y   <= signed'(i_cfg_data);
                    CFG_INTEGRATOR:  r_integrator  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_acc && (i_in_data.op == OP_STEP)) begin
                r_idx <= '0;
                r_n   <= n_eff;
            end else if (out_load && has_next) begin
                r_idx <= r_idx + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_mag;
        r_pneg <= m_a[32] ^ m_b[32];
        case (r_state)
            S_IDLE: begin
                r_fpx <= '0;
                r_fpy <= '0;
            end
            S_RD0: r_cur <= r_rd;
            S_RDN: begin
                r_nxt <= r_rd;
                if (!has_next) begin
                    r_fx <= '0;
                    r_fy <= '0;
                end
            end
            S_DIFF: begin
                r_dx <= f_sat32(52'(r_cur.px) - 52'(r_nxt.px));
                r_dy <= f_sat32(52'(r_cur.py) - 52'(r_nxt.py));
            end
            S_SQY: r_sq <= r_prod[63:0];
            S_SQW: if (sq_done) r_len <= sq_root;
            S_STR: r_stretch <= f_sat32(signed'(52'(r_len)) - signed'(52'(r_rest_length)));
            S_FV: begin
                r_f <= prod_s32;
                // A spring of zero length pulls in no direction.
                if (r_len == 32'd0) begin
                    r_fx <= '0;
                    r_fy <= '0;
                end
            end
            S_MY: begin
                r_prodx <= r_prod;
                r_pnegx <= r_pneg;
            end
            S_DIVS: r_pnegy <= r_pneg;
            S_DIVW: if (dvx_done) begin
                r_fx <= f_sat_mag(dvx_q, r_pnegx);
                r_fy <= f_sat_mag(dvy_q, r_pnegy);
            end
            S_SUM: begin
                r_tx  <= f_sat32(52'(r_fpx) - 52'(r_fx));
                r_ty  <= f_sat32(52'(r_fpy) - 52'(r_fy));
                r_npx <= r_cur.px;
                r_npy <= r_cur.py;
                r_nqx <= r_cur.qx;
                r_nqy <= r_cur.qy;
                r_nvx <= r_cur.vx;
                r_nvy <= r_cur.vy;
            end
            S_GX: r_tx <= f_sat32(52'(r_tx) + 52'(prod_s32));
            S_GY: r_ty <= f_sat32(52'(r_ty) + 52'(prod_s32));
            S_DX: r_tx <= f_sat32(52'(r_tx) - 52'(prod_q16));
            S_DY: r_ty <= f_sat32(52'(r_ty) - 52'(prod_q16));
            S_ACC: if (r_node_mass == 32'd0) begin
                // Without mass the acceleration pins to the rail of the force.
                r_tx <= r_tx[31] ? -32'sh80000000 : ((r_tx != 0) ? 32'sh7FFFFFFF : '0);
                r_ty <= r_ty[31] ? -32'sh80000000 : ((r_ty != 0) ? 32'sh7FFFFFFF : '0);
            end
            S_ACW: if (dvx_done) begin
                r_tx <= f_sat_mag(dvx_q, r_tx[31]);
                r_ty <= f_sat_mag(dvy_q, r_ty[31]);
            end
            S_V1: r_nvx <= f_sat32(52'(r_cur.vx) + 52'(prod_q16));
            S_V2: r_nvy <= f_sat32(52'(r_cur.vy) + 52'(prod_q16));
            S_V3: r_npx <= f_sat32(52'(r_cur.px) + 52'(prod_q16));
            S_V4: r_npy <= f_sat32(52'(r_cur.py) + 52'(prod_q16));
            S_W2: r_sx <= 33'(prod_q16);
            S_W4: r_sy <= 33'(prod_q16);
            S_W5: r_cx <= 33'(prod_q16);
            S_W6: begin
                r_cy  <= 33'(prod_q16);
                r_npx <= f_sat32(52'(r_cur.px) + 52'(r_cx) + 52'(r_sx));
            end
            S_W7: begin
                r_npy <= f_sat32(52'(r_cur.py) + 52'(r_cy) + 52'(r_sy));
                r_nqx <= r_cur.px;
                r_nqy <= r_cur.py;
            end
            S_EMIT: if (out_load) begin
                r_out.out_index <= 6'(r_idx);
                r_out.out_x     <= r_npx;
                r_out.out_y     <= r_npy;
                r_out.last_node <= !has_next;
                r_fpx           <= r_fx;
                r_fpy           <= r_fy;
                if (has_next) begin
                    r_cur <= r_nxt;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dvx_done == dvy_done)
        else $error("x and y dividers finished in different cycles");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == S_EMIT)) |-> (rd_addr != wr_addr))
        else $error("node memory read and write hit the same entry");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !has_next) |=> (r_state == S_IDLE))
        else $error("step did not end after its last node");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (CNT_W'(r_idx) < r_n))
        else $error("node index ran past the node count");
`endif

endmodule

### verif/rope_mass_spring_step_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_mass_spring_step_unit_tb
// Self-checking bench for the mass-spring chain step unit. Loads and steps go
// through a bursty driver, results are checked against an in-bench model of
// the chain under several register settings, Euler and Verlet alike.
// ----------------------------------------------------------------------------
module rope_mass_spring_step_unit_tb;
    import rmss_pkg::*;

    localparam int RUN_LIMIT = 1_000_000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    t_in_item            i_in_data   = '0;
    logic                i_out_ready = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_index = CFG_NODE_COUNT;
    logic [31:0]         i_cfg_data  = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    t_out_item           o_out_data;
    logic                o_cfg_ready;

    rope_mass_spring_step_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item expected_positions[$];
    int        mismatches    = 0;
    int        results_seen  = 0;
    int        cycle_count   = 0;

    // Chain state and register copies for the prediction.
    int pos_x[MAX_NODES], pos_y[MAX_NODES];
    int prv_x[MAX_NODES], prv_y[MAX_NODES];
    int vel_x[MAX_NODES], vel_y[MAX_NODES];
    int frc_x[MAX_NODES], frc_y[MAX_NODES];
    bit pin_flag[MAX_NODES];

    logic [CNT_W-1:0] cfg_count = RST_NODE_COUNT;
    logic [31:0]      cfg_k     = RST_SPRING_K;
    logic [31:0]      cfg_rest  = RST_REST_LENGTH;
    logic [31:0]      cfg_mass  = RST_NODE_MASS;
    logic [15:0]      cfg_dt    = RST_TIME_STEP;
    int               cfg_gx    = RST_GRAVITY_X;
    int               cfg_gy    = RST_GRAVITY_Y;
    logic             cfg_integ = INTEG_EULER;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned magn(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint scaled_div(input longint a, input longint b,
                                          input longint unsigned den);
        longint unsigned q;
        q = (magn(a) * magn(b)) / den;
        if (q > 64'h7FFF_FFFF_FFFF_FFFF) q = 64'h7FFF_FFFF_FFFF_FFFF;
        return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint q16_mul(input longint a, input longint b);
        return scaled_div(a, b, 64'd65536);
    endfunction

    function automatic longint accel_of(input longint f, input longint unsigned m);
        if (m == 0) return f > 0 ? 64'sd2147483647 : (f < 0 ? -64'sd2147483648 : 0);
        return clamp32(scaled_div(f, 65536, m));
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int nodes_in_use(input logic [CNT_W-1:0] c);
        if (c < 2) return 2;
        if (c > MAX_NODES) return MAX_NODES;
        return int'(c);
    endfunction

    task automatic advance_chain(input t_in_item it);
        int n, idx;
        longint dx, dy, stretch, f, fx, fy, ax, ay, sx, sy, cx, cy, nx, ny;
        longint mass, dt;
        longint unsigned len;
        t_out_item r;
        if (it.op == OP_LOAD) begin
            idx = it.node_index;
            pos_x[idx] = it.load_x; prv_x[idx] = it.load_x;
            pos_y[idx] = it.load_y; prv_y[idx] = it.load_y;
            vel_x[idx] = 0; vel_y[idx] = 0;
            pin_flag[idx] = it.pinned;
            return;
        end
        n = nodes_in_use(cfg_count);
        mass = longint'({32'b0, cfg_mass});
        dt = longint'({48'b0, cfg_dt});
        for (int i = 0; i < n; i++) begin
            frc_x[i] = 0; frc_y[i] = 0;
        end
        for (int i = 0; i + 1 < n; i++) begin
            dx = clamp32(longint'(pos_x[i]) - pos_x[i + 1]);
            dy = clamp32(longint'(pos_y[i]) - pos_y[i + 1]);
            len = int_sqrt(magn(dx) * magn(dx) + magn(dy) * magn(dy));
            stretch = clamp32(longint'(len) - longint'({32'b0, cfg_rest}));
            f = clamp32(q16_mul(longint'({32'b0, cfg_k}), stretch));
            fx = 0; fy = 0;
            // A zero-length spring has no direction and pushes nothing.
            if (len != 0) begin
                fx = clamp32(scaled_div(f, dx, len));
                fy = clamp32(scaled_div(f, dy, len));
            end
            frc_x[i]     = int'(clamp32(longint'(frc_x[i]) - fx));
            frc_y[i]     = int'(clamp32(longint'(frc_y[i]) - fy));
            frc_x[i + 1] = int'(clamp32(longint'(frc_x[i + 1]) + fx));
            frc_y[i + 1] = int'(clamp32(longint'(frc_y[i + 1]) + fy));
        end
        for (int i = 0; i < n; i++) begin
            if (!pin_flag[i]) begin
                fx = clamp32(frc_x[i] + clamp32(q16_mul(mass, cfg_gx)));
                fy = clamp32(frc_y[i] + clamp32(q16_mul(mass, cfg_gy)));
                if (cfg_integ == INTEG_EULER) begin
                    fx = clamp32(fx - q16_mul(vel_x[i], longint'(EULER_DAMP_Q16)));
                    fy = clamp32(fy - q16_mul(vel_y[i], longint'(EULER_DAMP_Q16)));
                    ax = accel_of(fx, mass);
                    ay = accel_of(fy, mass);
                    vel_x[i] = int'(clamp32(vel_x[i] + q16_mul(ax, dt)));
                    vel_y[i] = int'(clamp32(vel_y[i] + q16_mul(ay, dt)));
                    pos_x[i] = int'(clamp32(pos_x[i] + q16_mul(vel_x[i], dt)));
                    pos_y[i] = int'(clamp32(pos_y[i] + q16_mul(vel_y[i], dt)));
                end else begin
                    ax = accel_of(fx, mass);
                    ay = accel_of(fy, mass);
                    sx = q16_mul(q16_mul(ax, dt), dt);
                    sy = q16_mul(q16_mul(ay, dt), dt);
                    cx = q16_mul(clamp32(longint'(pos_x[i]) - prv_x[i]),
                                 longint'(VERLET_KEEP_Q16));
                    cy = q16_mul(clamp32(longint'(pos_y[i]) - prv_y[i]),
                                 longint'(VERLET_KEEP_Q16));
                    nx = clamp32(pos_x[i] + cx + sx);
                    ny = clamp32(pos_y[i] + cy + sy);
                    prv_x[i] = pos_x[i];
                    prv_y[i] = pos_y[i];
                    pos_x[i] = int'(nx);
                    pos_y[i] = int'(ny);
                end
            end
            frc_x[i] = 0; frc_y[i] = 0;
        end
        for (int i = 0; i < n; i++) begin
            r.out_index = 6'(i);
            r.out_x = pos_x[i];
            r.out_y = pos_y[i];
            r.last_node = (i == n - 1);
            expected_positions = {expected_positions, r};
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !o_in_ready)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in_data  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: its own stall pattern, plus one long hold-off while items pile up.
    int  hold_left  = 0;
    bit  long_done  = 1'b0;
    int  rx_mode    = 0;
    int  mode_left  = 0;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!long_done && results_seen >= 40) begin
            long_done = 1'b1;
            hold_left = 3000;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= $urandom_range(0, 1);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: predict on accepted inputs, check accepted results.
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            advance_chain(i_in_data);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_positions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: index %0d x %0d y %0d last %0b",
                             o_out_data.out_index, o_out_data.out_x,
                             o_out_data.out_y, o_out_data.last_node);
                end
            end else begin
                exp_item = expected_positions.pop_front();
                if (o_out_data.out_index !== exp_item.out_index ||
                    o_out_data.out_x !== exp_item.out_x ||
                    o_out_data.out_y !== exp_item.out_y ||
                    o_out_data.last_node !== exp_item.last_node) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp idx %0d x %0d y %0d last %0b",
                                 exp_item.out_index, exp_item.out_x,
                                 exp_item.out_y, exp_item.last_node);
                        $display("          got idx %0d x %0d y %0d last %0b",
                                 o_out_data.out_index, o_out_data.out_x,
                                 o_out_data.out_y, o_out_data.last_node);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("[rope_mass_spring_step_unit] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_NODE_COUNT:  cfg_count = value[CNT_W-1:0];
            CFG_SPRING_K:    cfg_k     = value;
            CFG_REST_LENGTH: cfg_rest  = value;
            CFG_NODE_MASS:   cfg_mass  = value;
            CFG_TIME_STEP:   cfg_dt    = value[15:0];
            CFG_GRAVITY_X:   cfg_gx    = value;
            CFG_GRAVITY_Y:   cfg_gy    = value;
            default:         cfg_integ = value[0];
        endcase
    endtask

    task automatic push_load(input int idx, input int x, input int y, input bit pin);
        t_in_item it;
        it.op = OP_LOAD;
        it.node_index = 6'(idx);
        it.load_x = x;
        it.load_y = y;
        it.pinned = pin;
        pending_items = {pending_items, it};
    endtask

    task automatic push_step();
        t_in_item it;
        it.op = OP_STEP;
        it.node_index = 6'($urandom);
        it.load_x = $urandom;
        it.load_y = $urandom;
        it.pinned = $urandom_range(0, 1);
        pending_items = {pending_items, it};
    endtask

    // Sender stays quiet until every expected result is back and the unit idles.
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_positions.size() != 0);
        repeat (200) @(posedge i_clk);
    endtask

    // One setting: write all registers, lay out a fresh rope when relay is set,
    // then step it with a few arbitrary loads mixed in.
    task automatic run_phase(input logic [31:0] cnt, input logic [31:0] k,
                             input logic [31:0] rest, input logic [31:0] mass,
                             input logic [31:0] dt, input logic [31:0] gx,
                             input logic [31:0] gy, input logic integ,
                             input int steps, input bit relay);
        int n;
        longint spacing;
        write_reg(CFG_NODE_COUNT, cnt);
        write_reg(CFG_SPRING_K, k);
        write_reg(CFG_REST_LENGTH, rest);
        write_reg(CFG_NODE_MASS, mass);
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_GRAVITY_X, gx);
        write_reg(CFG_GRAVITY_Y, gy);
        write_reg(CFG_INTEGRATOR, {31'b0, integ});
        n = nodes_in_use(cnt[CNT_W-1:0]);
        spacing = longint'({44'b0, rest[19:0]}) + $urandom_range(0, 32768);
        if (relay) begin
            for (int i = 0; i < n; i++) begin
                push_load(i, int'(spacing * i) + $urandom_range(0, 4096),
                          $urandom_range(0, 65536) - 32768, i == 0);
            end
        end
        for (int s = 0; s < steps; s++) begin
            push_step();
            if ($urandom_range(0, 2) == 0) begin
                push_load($urandom_range(0, MAX_NODES - 1), $urandom, $urandom,
                          $urandom_range(0, 1));
            end
        end
        wait_quiet();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: two nodes, Euler.
        push_load(0, 0, 0, 1'b1);
        push_load(1, 0, -65536, 1'b0);
        push_step();
        push_step();
        // Coincident nodes give a spring of zero length.
        push_load(1, 0, 0, 1'b0);
        push_step();
        // Opposite extremes saturate the spring vector.
        push_load(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        push_load(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        push_step();
        push_step();
        push_load(0, 1000, 2000, 1'b1);
        push_load(1, -3000, 4000, 1'b1);
        push_step();
        push_load(63, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1);
        push_load(62, 0, 0, 1'b0);
        wait_quiet();

        // Count below the minimum, stiffest spring, zero rest length.
        run_phase(0, 32'hFFFF_FFFF, 0, 65536, 655, 0, -655360, INTEG_EULER, 3, 1'b1);
        // Count of one, zero mass, full time step, extreme gravity, Verlet.
        run_phase(1, 0, 32'hFFFF_FFFF, 0, 65535, 32'h7FFF_FFFF, 32'h8000_0000,
                  INTEG_VERLET, 3, 1'b1);
        // Zero time step leaves only the Verlet carry.
        run_phase(5, 65536, 65536, 65536, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                  INTEG_VERLET, 3, 1'b1);
        // Count above the maximum clamps to the full chain.
        run_phase(127, 40000, 65536, 32'hFFFF_FFFF, 655, 0, -655360,
                  INTEG_VERLET, 3, 1'b1);
        run_phase(64, 65536, 65536, 65536, 1000, 6554, -655360, INTEG_EULER, 2, 1'b0);
        for (int p = 0; p < 4; p++) begin
            run_phase($urandom_range(2, 8), $urandom_range(0, 1 << 20),
                      $urandom_range(0, 3 << 16), $urandom_range(1, 1 << 20),
                      $urandom_range(1, 65535),
                      $urandom_range(0, 1 << 21) - (1 << 20),
                      $urandom_range(0, 1 << 21) - (1 << 20),
                      $urandom_range(0, 1), 5, 1'b1);
        end

        if (mismatches == 0 && expected_positions.size() == 0) begin
            $display("[rope_mass_spring_step_unit] OK");
        end else begin
            $display("[rope_mass_spring_step_unit] ERROR");
        end
        $finish;
    end

endmodule
